// ===== sv/hsv_to_rgb_converter_assert.svh =====
// Assertion helpers used by the converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Check in the same cycle.
`define HSV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check starting in the next cycle.
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    // Saturation and brightness full scale, tenths of a percent
    localparam logic [10:0] SV_MAX = 11'd1000;

    // Fixed color for out-of-range input
    localparam logic [7:0] ERR_RB = 8'd30;

    // Hue: 960 steps per 60-degree sector, 90 coarse steps (of 64) per turn
    localparam logic [10:0] HUE_SECTOR  = 11'd960;
    localparam logic [10:0] HUE_RECIP   = 11'd1457;
    localparam int          HUE_SHIFT   = 17;
    localparam logic [9:0]  HUE_TURN    = 10'd90;
    localparam logic [6:0]  COARSE_SPAN = 7'd15;
    localparam logic [6:0]  COARSE_PAIR = 7'd30;

    // Reciprocal of one million, exact floor for numerators below 2^28
    localparam logic [28:0] DIV_RECIP = 29'd281474977;
    localparam int          DIV_SHIFT = 48;

    // Scale factors that fold 255/960e6 into a single divide by one million
    localparam logic [19:0] SV_UNIT  = 20'd1000;
    localparam logic [29:0] MUL_SECT = 30'd960;
    localparam logic [27:0] MUL_FULL = 28'd255;
    localparam logic [27:0] MUL_TOP  = 28'd255000;
    localparam logic [33:0] MUL_SEVN = 34'd17;

    typedef enum logic [2:0] {
        SECT_RY,
        SECT_YG,
        SECT_GC,
        SECT_CB,
        SECT_BM,
        SECT_MR
    } sector_t;

    typedef struct packed {
        sector_t    sector;
        logic [9:0] weight;
    } hue_info_t;

endpackage

// ===== sv/hsv2rgb_hue.sv =====
module hsv2rgb_hue
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic [15:0] hue,
    output hue_info_t   info
);

    logic [9:0]  coarse;
    logic [20:0] prod;
    logic [3:0]  turns;
    logic [9:0]  turn_off;
    logic [6:0]  r90_next;
    logic [6:0]  r90_reg;
    logic [5:0]  fine_reg;

    logic [2:0]  sidx;
    logic [6:0]  pair_off;
    logic [4:0]  r30;
    logic [10:0] t;
    logic [10:0] from_mid;
    hue_info_t   info_next;
    hue_info_t   info_reg;

    // Reduce modulo one full turn on the coarse part; low six bits pass through
    assign coarse   = hue[15:6];
    assign prod     = 21'(coarse) * 21'(HUE_RECIP);
    assign turns    = prod[HUE_SHIFT +: 4];
    assign turn_off = 10'(turns) * HUE_TURN;
    assign r90_next = 7'(coarse - turn_off);

    always_ff @(posedge clk)
    begin
        r90_reg  <= r90_next;
        fine_reg <= hue[5:0];
    end

    always_comb
    begin
        if (r90_reg >= 7'(COARSE_SPAN * 7'd5))
            sidx = 3'd5;
        else if (r90_reg >= 7'(COARSE_SPAN * 7'd4))
            sidx = 3'd4;
        else if (r90_reg >= 7'(COARSE_SPAN * 7'd3))
            sidx = 3'd3;
        else if (r90_reg >= 7'(COARSE_SPAN * 7'd2))
            sidx = 3'd2;
        else if (r90_reg >= COARSE_SPAN)
            sidx = 3'd1;
        else
            sidx = 3'd0;
    end

    // Position within a 120-degree pair of sectors, then distance from its middle
    assign pair_off = 7'(sidx[2:1]) * COARSE_PAIR;
    assign r30      = 5'(r90_reg - pair_off);
    assign t        = {r30, fine_reg};
    assign from_mid = (t >= HUE_SECTOR) ? (t - HUE_SECTOR) : (HUE_SECTOR - t);

    always_comb
    begin
        info_next.sector = sector_t'(sidx);
        info_next.weight = 10'(HUE_SECTOR - from_mid);
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

// ===== sv/hsv2rgb_div1m.sv =====
module hsv2rgb_div1m
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic [27:0] num,
    output logic [7:0]  quo
);

    logic [56:0] prod;
    logic [7:0]  quo_reg;

    assign prod = 57'(num) * 57'(DIV_RECIP);

    always_ff @(posedge clk)
    begin
        quo_reg <= prod[DIV_SHIFT +: 8];
    end

    assign quo = quo_reg;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// HSV to 8-bit RGB converter, six register stages.
// Throughput: one pixel per clock; busy is held low, start is always taken.
// Done and the color appear together, both from the stage-6 registers.
// Depth is set by the reciprocal multipliers that replace the channel divides.
// Reset clears the valid chain and done; payload stages are not reset.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] hue,
    input  logic [10:0] saturation,
    input  logic [10:0] brightness,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        out_of_range
);

    logic        accept;
    logic [4:0]  vld_reg;
    logic        done_reg;

    logic [15:0] hue_s1_reg;
    logic [10:0] sat_s1_reg;
    logic [10:0] val_s1_reg;

    logic [19:0] chroma_s2_reg;
    logic [9:0]  val_s2_reg;
    logic        oor_s2_reg;

    logic [19:0] mnum_s3_reg;
    logic [19:0] chroma_s3_reg;
    logic [9:0]  val_s3_reg;
    logic        oor_s3_reg;
    hue_info_t   hinfo;

    logic [29:0] nx_next;
    logic [29:0] nx_s4_reg;
    logic [27:0] y0_s4_reg;
    logic [27:0] yc_s4_reg;
    sector_t     sector_s4_reg;
    logic        oor_s4_reg;

    logic [27:0] yx;
    logic [7:0]  ch_c;
    logic [7:0]  ch_x;
    logic [7:0]  ch_0;
    sector_t     sector_s5_reg;
    logic        oor_s5_reg;

    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        oor_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[3:0], accept};
            done_reg <= vld_reg[4];
        end
    end

    // Stage 1: capture the transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hue_s1_reg <= hue;
            sat_s1_reg <= saturation;
            val_s1_reg <= brightness;
        end
    end

    hsv2rgb_hue u_hue (
        .clk  (clk),
        .hue  (hue_s1_reg),
        .info (hinfo)
    );

    // Stage 2: chroma and range check
    always_ff @(posedge clk)
    begin
        chroma_s2_reg <= 20'(22'(sat_s1_reg) * 22'(val_s1_reg));
        val_s2_reg    <= val_s1_reg[9:0];
        oor_s2_reg    <= (sat_s1_reg > SV_MAX) || (val_s1_reg > SV_MAX);
    end

    // Stage 3: offset numerator v*1000 - C
    always_ff @(posedge clk)
    begin
        mnum_s3_reg   <= 20'(val_s2_reg) * SV_UNIT - chroma_s2_reg;
        chroma_s3_reg <= chroma_s2_reg;
        val_s3_reg    <= val_s2_reg;
        oor_s3_reg    <= oor_s2_reg;
    end

    // Stage 4: numerators of the three channel values
    assign nx_next = 30'(chroma_s3_reg) * 30'(hinfo.weight)
                   + 30'(mnum_s3_reg) * MUL_SECT;

    always_ff @(posedge clk)
    begin
        nx_s4_reg     <= nx_next;
        y0_s4_reg     <= 28'(mnum_s3_reg) * MUL_FULL;
        yc_s4_reg     <= 28'(val_s3_reg) * MUL_TOP;
        sector_s4_reg <= hinfo.sector;
        oor_s4_reg    <= oor_s3_reg;
    end

    // Stage 5: 255/960 equals 17/64, which leaves one divide by one million
    assign yx = 28'((34'(nx_s4_reg) * MUL_SEVN) >> 6);

    hsv2rgb_div1m u_div_c (
        .clk (clk),
        .num (yc_s4_reg),
        .quo (ch_c)
    );

    hsv2rgb_div1m u_div_x (
        .clk (clk),
        .num (yx),
        .quo (ch_x)
    );

    hsv2rgb_div1m u_div_0 (
        .clk (clk),
        .num (y0_s4_reg),
        .quo (ch_0)
    );

    always_ff @(posedge clk)
    begin
        sector_s5_reg <= sector_s4_reg;
        oor_s5_reg    <= oor_s4_reg;
    end

    // Stage 6: place components by sector, or the fixed error color when out of range
    always_comb
    begin
        if (oor_s5_reg)
        begin
            red_next   = ERR_RB;
            green_next = 8'd0;
            blue_next  = ERR_RB;
        end
        else
        begin
            unique case (sector_s5_reg)
                SECT_RY:
                begin
                    red_next = ch_c; green_next = ch_x; blue_next = ch_0;
                end
                SECT_YG:
                begin
                    red_next = ch_x; green_next = ch_c; blue_next = ch_0;
                end
                SECT_GC:
                begin
                    red_next = ch_0; green_next = ch_c; blue_next = ch_x;
                end
                SECT_CB:
                begin
                    red_next = ch_0; green_next = ch_x; blue_next = ch_c;
                end
                SECT_BM:
                begin
                    red_next = ch_x; green_next = ch_0; blue_next = ch_c;
                end
                default:
                begin
                    red_next = ch_c; green_next = ch_0; blue_next = ch_x;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        oor_reg   <= oor_s5_reg;
    end

    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign out_of_range = oor_reg;

    `HSV_ASSERT_NEXT(a_latency, start && !busy, ##5 done, "result strobe missing after transfer")
    `HSV_ASSERT_SAME(a_err_color, done && out_of_range, red == ERR_RB && green == 8'd0 && blue == ERR_RB, "out-of-range color wrong")
    `HSV_ASSERT_SAME(a_range_flag, done, out_of_range == ($past(saturation, 6) > SV_MAX || $past(brightness, 6) > SV_MAX), "range flag does not match input")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hsv2rgb_pkg::*;

    localparam longint unsigned STEPS_PER_TURN = 5760;
    localparam longint unsigned STEPS_PER_SECT = 960;
    localparam longint unsigned LEVEL_UNIT     = 1000;
    localparam longint unsigned SCALE_DENOM    = 960000000;
    localparam longint unsigned BYTE_SCALE     = 255;
    localparam int              RANDOM_PIXELS  = 1200;
    localparam int              TAIL_CYCLES    = 10;
    localparam int              STALL_LIMIT    = 1000;
    localparam int              REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       flag;
    } rgb_t;

    typedef struct packed {
        logic [15:0] h;
        logic [10:0] s;
        logic [10:0] v;
        logic        known;
        rgb_t        color;
    } pixel_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] hue = '0;
    logic [10:0] saturation = '0;
    logic [10:0] brightness = '0;
    logic        done;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        out_of_range;

    pixel_req_t pixels[$];
    rgb_t       pending_colors[$];
    int         next_idx = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         mismatches = 0;
    int         stall_cycles = 0;

    hsv_to_rgb_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .hue          (hue),
        .saturation   (saturation),
        .brightness   (brightness),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_of_range (out_of_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rgb_t predict_rgb(logic [15:0] h, logic [10:0] s, logic [10:0] v);
        longint unsigned hq, t, from_mid, w, chroma, moff, nc, nx, n0;
        logic [7:0] cc, cx, c0;
        sector_t sect;
        rgb_t res;
        if (s > SV_MAX || v > SV_MAX)
        begin
            res.r = ERR_RB;
            res.g = 8'd0;
            res.b = ERR_RB;
            res.flag = 1'b1;
        end
        else
        begin
            hq = longint'(h) % STEPS_PER_TURN;
            sect = sector_t'(hq / STEPS_PER_SECT);
            t = hq % (2 * STEPS_PER_SECT);
            from_mid = (t >= STEPS_PER_SECT) ? (t - STEPS_PER_SECT)
                                             : (STEPS_PER_SECT - t);
            w = STEPS_PER_SECT - from_mid;
            chroma = longint'(s) * longint'(v);
            moff = (LEVEL_UNIT * longint'(v) - chroma) * STEPS_PER_SECT;
            nc = chroma * STEPS_PER_SECT + moff;
            nx = chroma * w + moff;
            n0 = moff;
            cc = 8'((BYTE_SCALE * nc) / SCALE_DENOM);
            cx = 8'((BYTE_SCALE * nx) / SCALE_DENOM);
            c0 = 8'((BYTE_SCALE * n0) / SCALE_DENOM);
            res.flag = 1'b0;
            case (sect)
                SECT_RY:
                begin
                    res.r = cc; res.g = cx; res.b = c0;
                end
                SECT_YG:
                begin
                    res.r = cx; res.g = cc; res.b = c0;
                end
                SECT_GC:
                begin
                    res.r = c0; res.g = cc; res.b = cx;
                end
                SECT_CB:
                begin
                    res.r = c0; res.g = cx; res.b = cc;
                end
                SECT_BM:
                begin
                    res.r = cx; res.g = c0; res.b = cc;
                end
                default:
                begin
                    res.r = cc; res.g = c0; res.b = cx;
                end
            endcase
        end
        return res;
    endfunction

    function automatic void add_row(int h, int s, int v, bit known,
                                    int r = 0, int g = 0, int b = 0, bit flag = 1'b0);
        pixel_req_t p;
        p.h = 16'(h);
        p.s = 11'(s);
        p.v = 11'(v);
        p.known = known;
        p.color.r = 8'(r);
        p.color.g = 8'(g);
        p.color.b = 8'(b);
        p.color.flag = flag;
        pixels.push_back(p);
    endfunction

    function automatic int pick_level();
        int lvl;
        case ($urandom_range(0, 9))
            0: lvl = $urandom_range(0, 2047);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: lvl = 0;
                    1: lvl = 1;
                    2: lvl = 999;
                    3: lvl = 1000;
                    default: lvl = 1001;
                endcase
            end
            default: lvl = $urandom_range(0, 1000);
        endcase
        return lvl;
    endfunction

    function automatic int pick_hue();
        int h;
        case ($urandom_range(0, 4))
            0, 1: h = $urandom_range(0, 65535);
            2, 3: h = $urandom_range(0, 5759);
            default:
            begin
                // land on or next to a sector boundary, any turn
                h = $urandom_range(0, 67) * 960 + $urandom_range(0, 2) - 1;
                if (h < 0)
                    h = 0;
            end
        endcase
        return h;
    endfunction

    function automatic int idle_gap();
        int gap;
        case ($urandom_range(0, 5))
            0, 1, 2: gap = 0;
            3, 4: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 20);
        endcase
        return gap;
    endfunction

    initial
    begin
        // primaries and secondaries on sector boundaries
        add_row(0,     1000, 1000, 1, 255, 0,   0);
        add_row(960,   1000, 1000, 1, 255, 255, 0);
        add_row(1920,  1000, 1000, 1, 0,   255, 0);
        add_row(2880,  1000, 1000, 1, 0,   255, 255);
        add_row(3840,  1000, 1000, 1, 0,   0,   255);
        add_row(4800,  1000, 1000, 1, 255, 0,   255);
        // hue wrap
        add_row(5760,  1000, 1000, 1, 255, 0,   0);
        add_row(11520, 1000, 1000, 1, 255, 0,   0);
        add_row(65535, 1000, 1000, 0);
        // gray axis and black
        add_row(0,     0,    1000, 1, 255, 255, 255);
        add_row(12345, 0,    0,    1, 0,   0,   0);
        add_row(1234,  1000, 0,    1, 0,   0,   0);
        // out-of-range inputs
        add_row(0,     1001, 500,  1, 30,  0,   30,  1'b1);
        add_row(0,     500,  1001, 1, 30,  0,   30,  1'b1);
        add_row(65535, 2047, 2047, 1, 30,  0,   30,  1'b1);
        add_row(16'hAAAA, 11'h555, 11'h2AA, 1, 30, 0, 30, 1'b1);
        // just inside and just past sector edges, then assorted interior points
        add_row(959,   1000, 1000, 0);
        add_row(961,   1000, 1000, 0);
        add_row(5759,  1000, 1000, 0);
        add_row(480,   1000, 1000, 0);
        add_row(3000,  500,  800,  0);
        add_row(0,     1000, 1,    0);
        add_row(2000,  1,    1000, 0);
        add_row(16'h5555, 11'h2AA, 11'h2AA, 0);
        for (int i = 0; i < RANDOM_PIXELS; i++)
            add_row(pick_hue(), pick_level(), pick_level(), 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (next_idx < pixels.size() || pending_colors.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk)
    begin
        pixel_req_t p;
        logic hold;
        if (rst_n)
        begin
            hold = start && busy;
            if (start && !busy)
            begin
                p = pixels[next_idx];
                pending_colors.push_back(p.known ? p.color : predict_rgb(p.h, p.s, p.v));
                next_idx++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = idle_gap();
                end
            end
            if (hold)
            begin
                start <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (next_idx < pixels.size())
            begin
                p = pixels[next_idx];
                start <= 1'b1;
                hue <= p.h;
                saturation <= p.s;
                brightness <= p.v;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_colors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: rgb=(%0d,%0d,%0d) oor=%0b",
                                 red, green, blue, out_of_range);
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (red !== want.r || green !== want.g || blue !== want.b
                        || out_of_range !== want.flag)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: exp (%0d,%0d,%0d,%0b) got (%0d,%0d,%0d,%0b)",
                                     want.r, want.g, want.b, want.flag,
                                     red, green, blue, out_of_range);
                    end
                end
            end
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_hue.sv
sv/hsv2rgb_div1m.sv
sv/hsv_to_rgb_converter.sv
tb/sv/tb_top.sv
